@@ rtl/core/rnct_pkg.sv @@
// Shared types and constants of the RPM notch center tracker.
// No dependencies; the other files of the core except rnct_div refer to it by scoped names.
package rnct_pkg;

    localparam int ERPM_W      = 20;
    localparam int ERPM_FIELDS = 8;
    localparam int IN_W        = ERPM_W * ERPM_FIELDS;
    localparam int HZ_W        = 16;
    localparam int PP_W        = 6;
    localparam int PP_MAX      = (1 << PP_W) - 1;
    localparam int DIV_W       = 16;
    localparam int Q_FRAC      = 4;
    localparam int SEC_PER_MIN = 60;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_UPDATE_DIV  = 3'd0;
    localparam t_reg_idx REG_POLE_PAIRS  = 3'd1;
    localparam t_reg_idx REG_MIN_HZ      = 3'd2;
    localparam t_reg_idx REG_MAX_HZ      = 3'd3;
    localparam t_reg_idx REG_FIXED_HZ    = 3'd4;
    localparam t_reg_idx REG_SLEW_STEP   = 3'd5;

    localparam logic [DIV_W-1:0] RST_UPDATE_DIV = 16'd4;
    localparam logic [PP_W-1:0]  RST_POLE_PAIRS = 6'd7;
    localparam logic [HZ_W-1:0]  RST_MIN_HZ     = 16'd1280;
    localparam logic [HZ_W-1:0]  RST_MAX_HZ     = 16'd8000;
    localparam logic [HZ_W-1:0]  RST_FIXED_HZ   = 16'd0;
    localparam logic [HZ_W-1:0]  RST_SLEW_STEP  = 16'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_CLAMP,
        ST_MOVE,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/core/rnct_accum.sv @@
// Serial eRPM accumulator: one motor per cycle out of a shift register.
// Depends on rnct_pkg.
module rnct_accum #(
    parameter int MOTORS = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_load,
    input  logic [rnct_pkg::IN_W-1:0]                   i_tdata,
    output logic                                        o_busy,
    output logic [rnct_pkg::ERPM_W+$clog2(MOTORS)-1:0]  o_sum,
    output logic [$clog2(MOTORS+1)-1:0]                 o_run
);

    localparam int SUM_W = rnct_pkg::ERPM_W + $clog2(MOTORS);
    localparam int RUN_W = $clog2(MOTORS + 1);

    logic [rnct_pkg::ERPM_W-1:0] r_sh [MOTORS];
    logic                        r_busy;
    logic [RUN_W-1:0]            r_idx;
    logic [SUM_W-1:0]            r_sum;
    logic [RUN_W-1:0]            r_run;
    logic                        w_nz;

    assign w_nz = (r_sh[0] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + RUN_W'(1);
            if (r_idx == RUN_W'(MOTORS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // motor 0 sits at the head; the line shifts down one field per cycle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MOTORS; k++) begin
                r_sh[k] <= i_tdata[k*rnct_pkg::ERPM_W +: rnct_pkg::ERPM_W];
            end
            r_sum <= '0;
            r_run <= '0;
        end else if (r_busy) begin
            for (int k = 0; k < MOTORS - 1; k++) begin
                r_sh[k] <= r_sh[k+1];
            end
            if (w_nz) begin
                r_sum <= r_sum + SUM_W'(r_sh[0]);
                r_run <= r_run + RUN_W'(1);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_sum  = r_sum;
    assign o_run  = r_run;

endmodule

@@ rtl/core/rnct_div.sv @@
// Restoring divider, one quotient bit per cycle through a shift register.
// No package dependency.
module rnct_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_q[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // dividend bits leave at the top as quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

@@ rtl/core/rpm_notch_center_tracker_core.sv @@
// Top level of the RPM notch center tracker: handshakes, config registers,
// tick divider, control FSM, clamp and slew. Uses rnct_pkg, rnct_accum, rnct_div.
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+-------------------------------------
//  s_axis    | in  | tvalid / tready             | tdata: erpm_0..erpm_7, 20 b each
//  m_axis    | out | tvalid / tready             | tdata: center_hz, tuser: tracking
//  apb       | in  | psel, penable, pwrite, pready | paddr/pwdata/prdata, 6 registers
//
// A tick that does not hit the update divider is only counted; tready stays high.
// An updating tick holds tready low from accept through the serial accumulator, check,
// bit-serial divider, clamp, slew and emit steps. A stopped tick leaves after the check:
// to emit if tracking was engaged, else back to idle with no result beat. Reset is synchronous,
// active low: register defaults, FSM state, tick count, engagement, center and out valid.
// The emit step stalls only while a previous beat is still held in the output register.
module rpm_notch_center_tracker_core #(
    parameter int MOTORS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // erpm_0 [19:0], erpm_1 [39:20], ... erpm_7 [159:140]
    input  logic [rnct_pkg::IN_W-1:0]       i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // center_hz [15:0], Q12.4
    output logic [rnct_pkg::HZ_W-1:0]       o_m_axis_tdata,
    // tracking [0]
    output logic [0:0]                      o_m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rnct_pkg::APB_AW-1:0]     paddr,
    input  logic [rnct_pkg::APB_DW-1:0]     pwdata,
    output logic [rnct_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int SUM_W = rnct_pkg::ERPM_W + $clog2(MOTORS);
    localparam int RUN_W = $clog2(MOTORS + 1);
    localparam int NUM_W = SUM_W + rnct_pkg::Q_FRAC;
    localparam int DEN_W = $clog2(MOTORS * rnct_pkg::PP_MAX * rnct_pkg::SEC_PER_MIN + 1);
    localparam int HZ_W  = rnct_pkg::HZ_W;

    // configuration registers
    logic [rnct_pkg::DIV_W-1:0] r_update_div;
    logic [rnct_pkg::PP_W-1:0]  r_pole_pairs;
    logic [HZ_W-1:0]            r_min_hz;
    logic [HZ_W-1:0]            r_max_hz;
    logic [HZ_W-1:0]            r_fixed_hz;
    logic [HZ_W-1:0]            r_slew_step;

    // tracker state
    rnct_pkg::t_state           r_state;
    rnct_pkg::t_state           n_state;
    logic [rnct_pkg::DIV_W-1:0] r_tick;
    logic [HZ_W-1:0]            r_center;
    logic                       r_engaged;
    logic [HZ_W-1:0]            r_target;

    // output register
    logic                       r_out_valid;
    logic [HZ_W-1:0]            r_out_center;
    logic                       r_out_track;

    logic                       w_in_beat;
    logic                       w_out_free;
    logic                       w_cfg_wr;
    rnct_pkg::t_reg_idx         w_reg;
    logic [rnct_pkg::DIV_W:0]   n_tick_inc;
    logic                       w_fire;
    logic                       acc_load;
    logic                       acc_busy;
    logic [SUM_W-1:0]           acc_sum;
    logic [RUN_W-1:0]           acc_run;
    logic                       div_start;
    logic                       div_busy;
    logic [NUM_W-1:0]           div_quot;
    logic [rnct_pkg::PP_W-1:0]  w_pp;
    logic [DEN_W-1:0]           w_den;
    logic [HZ_W-1:0]            n_target;
    logic [HZ_W:0]              w_up;
    logic [HZ_W:0]              w_dn;
    logic [HZ_W-1:0]            w_moved;
    logic [HZ_W-1:0]            n_center;

    assign w_in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg      = rnct_pkg::t_reg_idx'(paddr[rnct_pkg::APB_AW-1:2]);

    // a divider of zero fires on every tick, like a divider of one
    assign n_tick_inc = {1'b0, r_tick} + (rnct_pkg::DIV_W+1)'(1);
    assign w_fire     = (n_tick_inc >= {1'b0, r_update_div});

    // ---------------------------------------------------------------
    // APB registers
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_div <= rnct_pkg::RST_UPDATE_DIV;
            r_pole_pairs <= rnct_pkg::RST_POLE_PAIRS;
            r_min_hz     <= rnct_pkg::RST_MIN_HZ;
            r_max_hz     <= rnct_pkg::RST_MAX_HZ;
            r_fixed_hz   <= rnct_pkg::RST_FIXED_HZ;
            r_slew_step  <= rnct_pkg::RST_SLEW_STEP;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                rnct_pkg::REG_UPDATE_DIV: r_update_div <= pwdata[rnct_pkg::DIV_W-1:0];
                rnct_pkg::REG_POLE_PAIRS: r_pole_pairs <= pwdata[rnct_pkg::PP_W-1:0];
                rnct_pkg::REG_MIN_HZ:     r_min_hz     <= pwdata[HZ_W-1:0];
                rnct_pkg::REG_MAX_HZ:     r_max_hz     <= pwdata[HZ_W-1:0];
                rnct_pkg::REG_FIXED_HZ:   r_fixed_hz   <= pwdata[HZ_W-1:0];
                rnct_pkg::REG_SLEW_STEP:  r_slew_step  <= pwdata[HZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            rnct_pkg::REG_UPDATE_DIV: prdata = rnct_pkg::APB_DW'(r_update_div);
            rnct_pkg::REG_POLE_PAIRS: prdata = rnct_pkg::APB_DW'(r_pole_pairs);
            rnct_pkg::REG_MIN_HZ:     prdata = rnct_pkg::APB_DW'(r_min_hz);
            rnct_pkg::REG_MAX_HZ:     prdata = rnct_pkg::APB_DW'(r_max_hz);
            rnct_pkg::REG_FIXED_HZ:   prdata = rnct_pkg::APB_DW'(r_fixed_hz);
            rnct_pkg::REG_SLEW_STEP:  prdata = rnct_pkg::APB_DW'(r_slew_step);
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath units
    // ---------------------------------------------------------------
    rnct_accum #(
        .MOTORS (MOTORS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (acc_load),
        .i_tdata (i_s_axis_tdata),
        .o_busy  (acc_busy),
        .o_sum   (acc_sum),
        .o_run   (acc_run)
    );

    // divisor = running * pole_pairs * 60, pole pairs of zero count as one
    assign w_pp  = (r_pole_pairs == '0) ? rnct_pkg::PP_W'(1) : r_pole_pairs;
    assign w_den = DEN_W'(acc_run) * DEN_W'(w_pp) * DEN_W'(rnct_pkg::SEC_PER_MIN);

    rnct_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({acc_sum, rnct_pkg::Q_FRAC'(0)}),
        .i_den   (w_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // clamp: below min wins over above max when the limits cross
    always_comb begin
        if (div_quot < NUM_W'(r_min_hz)) begin
            n_target = r_min_hz;
        end else if (div_quot > NUM_W'(r_max_hz)) begin
            n_target = r_max_hz;
        end else begin
            n_target = div_quot[HZ_W-1:0];
        end
    end

    // slew toward the target by at most the slew step once engaged, else snap to it; 17-bit sums cannot wrap
    always_comb begin
        w_up = {1'b0, r_center} + {1'b0, r_slew_step};
        w_dn = {1'b0, r_target} + {1'b0, r_slew_step};
        priority if ({1'b0, r_target} > w_up) begin
            w_moved = w_up[HZ_W-1:0];
        end else if (w_dn < {1'b0, r_center}) begin
            w_moved = r_center - r_slew_step;
        end else begin
            w_moved = r_target;
        end
        n_center = r_engaged ? w_moved : r_target;
    end

    // ---------------------------------------------------------------
    // control FSM
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rnct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        acc_load        = 1'b0;
        div_start       = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            rnct_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (w_in_beat && w_fire) begin
                    acc_load = 1'b1;
                    n_state  = rnct_pkg::ST_SUM;
                end
            end
            rnct_pkg::ST_SUM: begin
                if (!acc_busy) begin
                    n_state = rnct_pkg::ST_CHECK;
                end
            end
            rnct_pkg::ST_CHECK: begin
                if (acc_run == '0) begin
                    n_state = r_engaged ? rnct_pkg::ST_EMIT : rnct_pkg::ST_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = rnct_pkg::ST_DIV;
                end
            end
            rnct_pkg::ST_DIV: begin
                if (!div_busy) begin
                    n_state = rnct_pkg::ST_CLAMP;
                end
            end
            rnct_pkg::ST_CLAMP: n_state = rnct_pkg::ST_MOVE;
            rnct_pkg::ST_MOVE:  n_state = rnct_pkg::ST_EMIT;
            rnct_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = rnct_pkg::ST_IDLE;
                end
            end
            default: n_state = rnct_pkg::ST_IDLE;
        endcase
    end

    // tick counter, engagement and center
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_engaged <= 1'b0;
            r_center  <= rnct_pkg::RST_FIXED_HZ;
        end else begin
            if (w_in_beat) begin
                r_tick <= w_fire ? '0 : n_tick_inc[rnct_pkg::DIV_W-1:0];
            end
            if (r_state == rnct_pkg::ST_CHECK && acc_run == '0 && r_engaged) begin
                // motors stopped: fall back to the fixed center
                r_center  <= r_fixed_hz;
                r_engaged <= 1'b0;
            end else if (r_state == rnct_pkg::ST_MOVE) begin
                // first running update snaps, later ones slew
                r_center  <= n_center;
                r_engaged <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rnct_pkg::ST_CLAMP) begin
            r_target <= n_target;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rnct_pkg::ST_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rnct_pkg::ST_EMIT && w_out_free) begin
            r_out_center <= r_center;
            r_out_track  <= r_engaged;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_center;
    assign o_m_axis_tuser  = r_out_track;

endmodule

@@ rtl/core/rnct_checker.sv @@
// Port-level checker for the RPM notch center tracker, bound to the top level.
// Depends on rnct_pkg for port widths.
module rnct_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [rnct_pkg::HZ_W-1:0]       o_m_axis_tdata,
    input logic [0:0]                      o_m_axis_tuser
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result payload changed while stalled");

    // a new result is loaded only from the busy side, never straight from idle
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without a processing step");

    // an input beat cannot produce a result on the very next edge
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result followed an input beat too early");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind rpm_notch_center_tracker_core rnct_checker u_rnct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
